// ===== sv/pcf_pkg.sv =====
package pcf_pkg;

	localparam int unsigned TYPE_W = 32;
	localparam int unsigned LEN_W  = 31;
	localparam int unsigned BYTE_W = 8;

	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

	// Input word layout: chunk_type, chunk_length, data_byte, zero pad.
	localparam int unsigned IN_DATA_W = 72;

	typedef enum logic [1:0] {
		KIND_ERR   = 2'd0,
		KIND_BEGIN = 2'd1,
		KIND_DATA  = 2'd2
	} cmd_kind_t;

	// flag: zero length on begin, last data byte on data.
	typedef struct packed {
		cmd_kind_t           kind;
		logic                flag;
		logic [TYPE_W-1:0]   chunk_type;
		logic [LEN_W-1:0]    chunk_length;
		logic [BYTE_W-1:0]   data_byte;
	} cmd_t;

endpackage

// ===== sv/pcf_front.sv =====
module pcf_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         operation,
	input  logic [pcf_pkg::TYPE_W-1:0]   chunk_type,
	input  logic [pcf_pkg::LEN_W-1:0]    chunk_length,
	input  logic [pcf_pkg::BYTE_W-1:0]   data_byte,
	output logic                         push,
	output pcf_pkg::cmd_t                push_cmd,
	input  logic                         q_full
);

	logic                       chunk_open_q;
	logic [pcf_pkg::LEN_W-1:0]  bytes_left_q;
	logic                       bad;
	logic                       last_byte;

	assign in_ready  = !q_full;
	assign push      = in_valid && in_ready;
	// begin with a chunk open, or data with none open
	assign bad       = (operation == chunk_open_q) ? 1'b0 : 1'b1;
	assign last_byte = (bytes_left_q == pcf_pkg::LEN_W'(1));

	always_comb begin
		push_cmd.chunk_type   = chunk_type;
		push_cmd.chunk_length = chunk_length;
		push_cmd.data_byte    = data_byte;
		if (bad) begin
			push_cmd.kind = pcf_pkg::KIND_ERR;
			push_cmd.flag = 1'b0;
		end else if (!operation) begin
			push_cmd.kind = pcf_pkg::KIND_BEGIN;
			push_cmd.flag = (chunk_length == '0);
		end else begin
			push_cmd.kind = pcf_pkg::KIND_DATA;
			push_cmd.flag = last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_open_q <= 1'b0;
			bytes_left_q <= '0;
		end else if (push && !bad) begin
			if (!operation) begin
				chunk_open_q <= (chunk_length != '0);
				bytes_left_q <= chunk_length;
			end else if (last_byte) begin
				chunk_open_q <= 1'b0;
				bytes_left_q <= '0;
			end else begin
				bytes_left_q <= bytes_left_q - pcf_pkg::LEN_W'(1);
			end
		end
	end

endmodule

// ===== sv/pcf_queue.sv =====
module pcf_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  pcf_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output pcf_pkg::cmd_t head
);

	pcf_pkg::cmd_t mem_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// ===== sv/pcf_back.sv =====
module pcf_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  pcf_pkg::cmd_t head,
	output logic          pop,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [7:0]    m_tdata,
	output logic [1:0]    m_tuser,
	output logic          m_tlast
);

	localparam logic [3:0] STEP_TYPE0    = 4'd4;
	localparam logic [3:0] STEP_HDR_LAST = 4'd7;
	localparam logic [3:0] STEP_ZERO_END = 4'd11;
	localparam logic [3:0] STEP_DATA_END = 4'd4;

	function automatic logic [7:0] byte_of(input logic [31:0] w, input logic [1:0] idx);
		logic [7:0] b;
		case (idx)
			2'd0:    b = w[31:24];
			2'd1:    b = w[23:16];
			2'd2:    b = w[15:8];
			default: b = w[7:0];
		endcase
		return b;
	endfunction

	function automatic logic [31:0] fold_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? (pcf_pkg::CRC_POLY ^ (c >> 1)) : (c >> 1);
		end
		return c;
	endfunction

	logic [31:0] crc_q;
	logic [3:0]  step_q;
	logic        m_tvalid_q;
	logic [7:0]  m_tdata_q;
	logic [1:0]  m_tuser_q;
	logic        m_tlast_q;

	logic        advance;
	logic        emit;
	logic [3:0]  last_step;
	logic [3:0]  step_m1;
	logic [7:0]  cur_byte;
	logic        fold_en;
	logic [31:0] crc_base;
	logic        is_final;
	logic        is_end;
	logic        is_err;
	logic [31:0] crc_out;

	assign advance = !m_tvalid_q || m_tready;
	assign emit    = head_valid && advance;
	assign step_m1 = step_q - 4'd1;
	assign crc_out = crc_q ^ pcf_pkg::CRC_ONES;

	always_comb begin
		cur_byte  = 8'd0;
		fold_en   = 1'b0;
		last_step = 4'd0;
		is_err    = 1'b0;
		crc_base  = crc_q;
		case (head.kind)
			pcf_pkg::KIND_BEGIN: begin
				last_step = head.flag ? STEP_ZERO_END : STEP_HDR_LAST;
				case (step_q[3:2])
					2'd0:    cur_byte = byte_of({1'b0, head.chunk_length}, step_q[1:0]);
					2'd1: begin
						cur_byte = byte_of(head.chunk_type, step_q[1:0]);
						fold_en  = 1'b1;
						if (step_q == STEP_TYPE0) begin
							crc_base = pcf_pkg::CRC_ONES;
						end
					end
					default: cur_byte = byte_of(crc_out, step_q[1:0]);
				endcase
			end
			pcf_pkg::KIND_DATA: begin
				last_step = head.flag ? STEP_DATA_END : 4'd0;
				if (step_q == 4'd0) begin
					cur_byte = head.data_byte;
					fold_en  = 1'b1;
				end else begin
					cur_byte = byte_of(crc_out, step_m1[1:0]);
				end
			end
			default: begin
				is_err = 1'b1;
			end
		endcase
	end

	assign is_final = (step_q == last_step);
	assign is_end   = is_final && head.flag && !is_err;
	assign pop      = emit && is_final;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q      <= pcf_pkg::CRC_ONES;
			step_q     <= 4'd0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (advance) begin
				m_tvalid_q <= head_valid;
			end
			if (emit) begin
				step_q <= is_final ? 4'd0 : step_q + 4'd1;
				if (is_end) begin
					crc_q <= pcf_pkg::CRC_ONES;
				end else if (fold_en) begin
					crc_q <= fold_byte(crc_base, cur_byte);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_tdata_q <= cur_byte;
			m_tuser_q <= {is_err, is_end};
			m_tlast_q <= is_final;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && m_tuser_q[0] |-> m_tlast_q)
		else $error("chunk end without end of run");
	a_err_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && m_tuser_q[1] |-> m_tlast_q && m_tdata_q == 8'd0)
		else $error("error word malformed");
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= STEP_ZERO_END)
		else $error("step counter out of range");
	a_crc_restart: assert property (@(posedge clk) disable iff (!arst_n)
		emit && is_end |=> crc_q == pcf_pkg::CRC_ONES)
		else $error("crc not restarted after chunk close");

endmodule

// ===== sv/png_chunk_framer_crc32_unit.sv =====
// Channel  Dir  Width            Words
// s_*      in   tdata 72, user 1 one item: begin (type, length) or one data byte
// m_*      out  tdata 8, user 2  one byte of the framed chunk stream, tlast per run
//
// The output port moves one byte per cycle while m_tready is high; that port sets the rate.
// Begin: 8 output bytes (12 for zero length). Data: 1 byte (5 on the last
// byte). Out-of-sequence item: 1 byte. The front side takes one item per cycle
// while the 2-entry command queue has room.
// The CRC folds one byte per cycle, as each type or data byte leaves.
// Reset (arst_n low) empties the queue, closes any chunk and sets the CRC to ones.
// m_tready low holds the output register; the queue then fills and s_tready drops.
module png_chunk_framer_crc32_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// [31:0] chunk_type, [62:32] chunk_length, [70:63] data_byte, [71] zero
	input  logic [pcf_pkg::IN_DATA_W-1:0]         s_tdata,
	// [0] operation: 0 begin, 1 data byte
	input  logic                                  s_tuser,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// [7:0] out_byte
	output logic [7:0]                            m_tdata,
	// [0] chunk_end, [1] error
	output logic [1:0]                            m_tuser,
	// last_of_run
	output logic                                  m_tlast
);

	logic          push;
	pcf_pkg::cmd_t push_cmd;
	logic          q_full;
	logic          pop;
	logic          head_valid;
	pcf_pkg::cmd_t head;

	// Front: sequence check, open/close tracking, command build.
	pcf_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.operation    (s_tuser),
		.chunk_type   (s_tdata[31:0]),
		.chunk_length (s_tdata[62:32]),
		.data_byte    (s_tdata[70:63]),
		.push         (push),
		.push_cmd     (push_cmd),
		.q_full       (q_full)
	);

	// Two-entry command queue decouples input acceptance from byte output.
	pcf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// Back: byte sequencer, CRC, output register.
	pcf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule

// ===== dv/png_chunk_framer_crc32_unit_tb.sv =====
module png_chunk_framer_crc32_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// operation codes carried on s_tuser
	localparam logic OP_BEGIN = 1'b0;
	localparam logic OP_DATA  = 1'b1;

	localparam int WATCHDOG_LIMIT = 2000; // cycles with no word moving on either side
	localparam int DRAIN_TAIL     = 16;   // settle time once nothing is outstanding
	localparam int HOLD_CYCLES    = 150;  // long output stall for the backpressure test
	localparam int MAX_REPORTS    = 40;

	typedef logic [pcf_pkg::TYPE_W-1:0] ctype_t;
	typedef logic [pcf_pkg::LEN_W-1:0]  len_t;
	typedef logic [pcf_pkg::BYTE_W-1:0] dbyte_t;

	// one byte of the framed stream as the block should emit it
	typedef struct packed {
		dbyte_t out_byte;
		logic   chunk_end;
		logic   last_of_run;
		logic   error;
	} framed_byte_t;

	logic                          clk      = 1'b0;
	logic                          arst_n   = 1'b0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [pcf_pkg::IN_DATA_W-1:0] s_tdata  = '0;
	logic                          s_tuser  = 1'b0;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [7:0]                    m_tdata;
	logic [1:0]                    m_tuser;
	logic                          m_tlast;

	// framer state as predicted from the accepted words
	logic [31:0]       crc_run    = pcf_pkg::CRC_ONES;
	len_t              bytes_due  = '0;
	logic              chunk_live = 1'b0;
	framed_byte_t      frame_q[$];

	int  fail_count   = 0;
	int  items_in     = 0;
	int  words_out    = 0;
	int  chunks_shut  = 0;
	int  seq_errors   = 0;
	int  good_items   = 0;
	int  quiet_cycles = 0;
	bit  idle_en      = 1'b1;
	int  hold_len     = 0;

	png_chunk_framer_crc32_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------------

	// reflected CRC-32, one byte, LSB first
	function automatic logic [31:0] crc32_fold_byte(logic [31:0] crc, logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'h0, b};
		for (int k = 0; k < 8; k++)
			c = c[0] ? (pcf_pkg::CRC_POLY ^ (c >> 1)) : (c >> 1);
		return c;
	endfunction

	// add one expected byte at the tail of frame_q
	function automatic void append_byte(framed_byte_t fb);
		frame_q = {frame_q, fb};
	endfunction

	// four bytes, most significant first; chunk_end marks the last CRC byte
	function automatic void push_be32(logic [31:0] w, logic is_crc);
		for (int i = 3; i >= 0; i--)
			append_byte(framed_byte_t'{w[i*8 +: 8], is_crc && (i == 0), 1'b0, 1'b0});
	endfunction

	function automatic void close_chunk_bytes();
		push_be32(crc_run ^ pcf_pkg::CRC_ONES, 1'b1);
		crc_run    = pcf_pkg::CRC_ONES;
		bytes_due  = '0;
		chunk_live = 1'b0;
		chunks_shut++;
	endfunction

	// expected bytes for one accepted word, appended to frame_q
	function automatic void frame_predict(logic op, ctype_t ctype, len_t clen, dbyte_t dbyte);
		framed_byte_t fb;
		// out of sequence: single flagged byte, state untouched
		if ((op == OP_BEGIN && chunk_live) || (op == OP_DATA && !chunk_live)) begin
			append_byte(framed_byte_t'{8'h00, 1'b0, 1'b1, 1'b1});
			seq_errors++;
			return;
		end
		if (op == OP_BEGIN) begin
			push_be32({1'b0, clen}, 1'b0);
			push_be32(ctype, 1'b0);
			crc_run = pcf_pkg::CRC_ONES;
			for (int s = 3; s >= 0; s--)
				crc_run = crc32_fold_byte(crc_run, ctype[s*8 +: 8]);
			if (clen == '0) begin
				close_chunk_bytes(); // empty chunk: CRC follows the header directly
			end else begin
				bytes_due  = clen;
				chunk_live = 1'b1;
			end
		end else begin
			append_byte(framed_byte_t'{dbyte, 1'b0, 1'b0, 1'b0});
			crc_run   = crc32_fold_byte(crc_run, dbyte);
			bytes_due = bytes_due - 1'b1;
			if (bytes_due == '0)
				close_chunk_bytes();
		end
		// tlast goes on the final byte this word produced
		fb = frame_q.pop_back();
		fb.last_of_run = 1'b1;
		append_byte(fb);
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (fail_count < MAX_REPORTS)
			$display("MISMATCH @%0t: %s expected 0x%0h got 0x%0h", $time, what, want, got);
		fail_count++;
	endtask

	// ---------------------------------------------------------------------
	// Monitor: predicts on input words, checks output words, watchdog
	// ---------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		framed_byte_t want;
		if (arst_n) begin
			// input side first so a word's bytes are queued before any can show up
			if (s_tvalid && s_tready) begin
				frame_predict(s_tuser, s_tdata[31:0], s_tdata[62:32], s_tdata[70:63]);
				items_in++;
			end
			if (m_tvalid && m_tready) begin
				words_out++;
				if (frame_q.size() == 0) begin
					report_mismatch("output word with nothing pending, out_byte", 32'h0,
						{24'h0, m_tdata});
				end else begin
					want = frame_q.pop_front();
					if (m_tdata !== want.out_byte)
						report_mismatch("out_byte", 32'(want.out_byte), 32'(m_tdata));
					if (m_tuser[0] !== want.chunk_end)
						report_mismatch("chunk_end", 32'(want.chunk_end), 32'(m_tuser[0]));
					if (m_tuser[1] !== want.error)
						report_mismatch("error", 32'(want.error), 32'(m_tuser[1]));
					if (m_tlast !== want.last_of_run)
						report_mismatch("last_of_run", 32'(want.last_of_run), 32'(m_tlast));
				end
			end
		end
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("TIMEOUT: no word moved for %0d cycles, %0d bytes pending",
					quiet_cycles, frame_q.size());
				$display("Verification failed");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Output sink: random stalls per word, plus an optional long hold-off
	// ---------------------------------------------------------------------
	initial begin : sink
		int stall;
		forever begin
			if (hold_len > 0) begin
				m_tready <= 1'b0;
				repeat (hold_len) @(posedge clk);
				hold_len = 0;
			end
			stall = idle_en ? $urandom_range(0, 3) : 0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------------

	// Gap is drawn ahead of the word so tvalid stays high between words when it is 0.
	// Entered and left right after a rising edge.
	task automatic send_item(input logic op, input ctype_t ctype, input len_t clen,
			input dbyte_t dbyte);
		int gap;
		gap = idle_en ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tuser  <= op;
		s_tdata  <= {1'b0, dbyte, clen, ctype};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
	endtask

	// sender stops and waits until every predicted byte has come back;
	// it waits for a clock edge first so the last accepted word is already predicted
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (frame_q.size() != 0) @(posedge clk);
		repeat (DRAIN_TAIL) @(posedge clk);
	endtask

	// unused fields carry random junk; the block must ignore them
	task automatic send_data(input dbyte_t dbyte);
		send_item(OP_DATA, $urandom(), len_t'($urandom()), dbyte);
	endtask

	task automatic send_begin(input ctype_t ctype, input len_t clen);
		send_item(OP_BEGIN, ctype, clen, dbyte_t'($urandom()));
	endtask

	// one well-formed chunk; noisy adds stray begins inside and stray data after
	task automatic send_chunk(input ctype_t ctype, input int clen, input bit noisy);
		send_begin(ctype, len_t'(clen));
		for (int i = 0; i < clen; i++) begin
			if (noisy && $urandom_range(0, 11) == 0)
				send_begin($urandom(), len_t'($urandom_range(0, 5)));
			send_data(dbyte_t'($urandom()));
		end
		if (noisy && $urandom_range(0, 5) == 0)
			send_data(dbyte_t'($urandom()));
		good_items += 1 + clen;
	endtask

	// mostly short chunks, some empty, a few longer
	function automatic int pick_length();
		int r;
		r = $urandom_range(0, 9);
		if (r < 2)
			return 0;
		else if (r < 8)
			return $urandom_range(1, 6);
		return $urandom_range(7, 24);
	endfunction

	// ---------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------

	// field extremes, both operations, both out-of-sequence cases, empty chunk
	task automatic test_directed();
		send_data(8'h5A);                       // data with no chunk open
		send_begin(32'h49454E44, '0);           // "IEND", empty chunk
		send_begin(32'hFFFFFFFF, 31'd1);
		send_data(8'hFF);
		send_begin(32'h00000000, 31'd2);
		send_begin(32'h49484452, 31'd13);       // begin while open: rejected
		send_data(8'h00);
		send_data(8'h80);
		send_data(8'h11);                       // stray after close
		send_begin(32'h49444154, 31'd3);        // "IDAT"
		send_data(8'h01);
		send_data(8'hFE);
		send_data(8'h7F);
		send_begin(32'h00000000, '0);
		good_items += 11;
		wait_drained();
	endtask

	// bulk of the run: random chunks with some noise, one drain pause midway
	task automatic test_random_chunks(input int target);
		int start;
		bit paused;
		start  = good_items;
		paused = 1'b0;
		while (good_items - start < target) begin
			send_chunk($urandom(), pick_length(), 1'b1);
			if (!paused && good_items - start >= target / 2) begin
				wait_drained();
				paused = 1'b1;
			end
		end
		wait_drained();
	endtask

	// back-to-back words with no idling on either side
	task automatic test_no_idle(input int target);
		int start;
		idle_en = 1'b0;
		start   = good_items;
		while (good_items - start < target)
			send_chunk($urandom(), $urandom_range(0, 5), 1'b1);
		wait_drained();
		idle_en = 1'b1;
	endtask

	// output held off long enough for the command queue to fill and stall the input
	task automatic test_backpressure();
		idle_en  = 1'b0;
		hold_len = HOLD_CYCLES;
		for (int i = 0; i < 4; i++)
			send_chunk($urandom(), 2, 1'b0);
		wait_drained();
		idle_en = 1'b1;
	endtask

	// largest length: chunk is left open, so this goes last
	task automatic test_max_length();
		send_begin($urandom(), {pcf_pkg::LEN_W{1'b1}});
		for (int i = 0; i < 6; i++)
			send_data(dbyte_t'($urandom()));
		send_begin($urandom(), '0);             // rejected, chunk still open
		good_items += 7;
		wait_drained();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_chunks(45);
		test_no_idle(25);
		test_backpressure();
		test_max_length();

		$display("Run: %0d words in (%0d in sequence, %0d out of sequence), %0d bytes out",
			items_in, good_items, seq_errors, words_out);
		$display("Run: %0d chunks closed incl. empty ones, long output stall, drain pause",
			chunks_shut);
		if (fail_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("Verification failed");
		end
		$finish;
	end

endmodule
